### rtl/lfu_pkg.sv
// Package for the LFU cache table: beat types, action codes and the
// request item passed from the front end to the table engine.
// No dependencies.
package lfu_pkg;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    localparam int          CAP_REG_W   = 5;
    localparam logic [4:0]  CAP_RESET   = 5'd16;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

    // queued request plus its classification
    typedef struct packed {
        req_t req;
        logic bypass;   // cache disabled: answer with all fields zero
    } item_t;

endpackage

### rtl/lfu_ifs.sv
// Valid/ready channel interfaces for the LFU cache table.
// Depends on lfu_pkg.
interface lfu_req_if;
    logic          valid;
    logic          ready;
    lfu_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
    logic          valid;
    logic          ready;
    lfu_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/lfu_cache_table_unit.sv
// LFU cache table: fully associative key/value store with least-frequently-
// used replacement, oldest entry first among equal counts. A get or a put
// to a present key passes lookup and decide in the table engine; a put of a
// new key adds an insert, and when the table is full first a victim scan
// visiting one entry per cycle and an eviction. A two-beat queue in front
// and a result register behind let both sides stall independently.
// Depends on lfu_pkg, lfu_ifs, lfu_front and lfu_back.
module lfu_cache_table_unit #(
    parameter int CAPACITY   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    lfu_req_if.sink    req,
    lfu_rsp_if.source  rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic             q_valid;
    lfu_pkg::item_t   q_item;
    logic             q_pop;
    logic [OCC_W-1:0] cap_eff;

    lfu_front #(
        .CAPACITY (CAPACITY),
        .OCC_W    (OCC_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cap_eff   (cap_eff)
    );

    lfu_back #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS),
        .OCC_W      (OCC_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .cap_eff (cap_eff),
        .rsp     (rsp)
    );

endmodule

### rtl/lfu_front.sv
// Front end: capacity register, request classification and a two-deep
// queue towards the table engine.
// Depends on lfu_pkg and lfu_ifs.
module lfu_front #(
    parameter int CAPACITY = 16,
    parameter int OCC_W    = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    lfu_req_if.sink              req,
    output logic                 q_valid,
    output lfu_pkg::item_t       q_item,
    input  logic                 q_pop,
    output logic [OCC_W-1:0]     cap_eff
);

    logic [lfu_pkg::CAP_REG_W-1:0] cap_reg;
    lfu_pkg::item_t                mem_reg [2];
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    cnt_reg;
    logic                          push;
    lfu_pkg::item_t                in_item;

    // capacity clipped to the table size
    assign cap_eff = (32'(cap_reg) > 32'(CAPACITY)) ? OCC_W'(CAPACITY) : OCC_W'(cap_reg);

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.req    = req.data;
        in_item.bypass = (cap_eff == '0);
    end

    // control: capacity register and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= lfu_pkg::CAP_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, q_pop && q_valid})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

### rtl/lfu_back.sv
// Table engine: entry storage, key match, victim scan, recency and count
// updates, and the result register.
// Depends on lfu_pkg and lfu_ifs.
module lfu_back #(
    parameter int CAPACITY   = 16,
    parameter int COUNT_BITS = 16,
    parameter int OCC_W      = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  lfu_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic [OCC_W-1:0] cap_eff,
    lfu_rsp_if.source        rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_DECIDE, ST_SCAN, ST_EVICT, ST_INSERT, ST_DONE
    } state_t;

    state_t                  state_reg;
    lfu_pkg::item_t          cur_reg;
    lfu_pkg::rsp_t           res_reg;
    logic                    out_valid_reg;
    lfu_pkg::rsp_t           out_data_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic                    vic_found_reg;
    logic [IDX_W-1:0]        vic_idx_reg;
    logic [COUNT_BITS-1:0]   vic_cnt_reg;
    logic [RANK_W-1:0]       vic_rank_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic [CAPACITY-1:0]     valid_reg;

    logic signed [31:0]      key_reg   [CAPACITY];
    logic signed [31:0]      value_reg [CAPACITY];
    logic [COUNT_BITS-1:0]   count_reg [CAPACITY];
    logic [RANK_W-1:0]       rank_reg  [CAPACITY];

    logic                    match_any;
    logic [IDX_W-1:0]        match_idx;
    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;
    logic                    scan_better;
    logic                    is_put;

    assign is_put    = (cur_reg.req.action == lfu_pkg::ACT_PUT);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // key match and first free slot, lowest index wins
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == cur_reg.req.lookup_key)
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // victim test for the entry under the scan pointer
    assign scan_better = valid_reg[scan_idx_reg] &&
                         (!vic_found_reg ||
                          count_reg[scan_idx_reg] < vic_cnt_reg ||
                          (count_reg[scan_idx_reg] == vic_cnt_reg &&
                           rank_reg[scan_idx_reg] > vic_rank_reg));

    // sequencer, valid bits, occupancy and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            hit_reg       <= 1'b0;
            vic_found_reg <= 1'b0;
        end
        else
        begin
            // result beat loads once the previous one has left
            if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_item;
                        res_reg   <= '0;
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    hit_reg   <= match_any;
                    slot_reg  <= match_idx;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    priority if (cur_reg.bypass)
                        state_reg <= ST_DONE;
                    else if (hit_reg)
                    begin
                        res_reg.hit        <= 1'b1;
                        res_reg.read_value <= is_put ? 32'sd0 : value_reg[slot_reg];
                        state_reg          <= ST_DONE;
                    end
                    else if (!is_put)
                        state_reg <= ST_DONE;
                    else if (occ_reg >= cap_eff)
                    begin
                        scan_idx_reg  <= '0;
                        vic_found_reg <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                    else
                        state_reg <= ST_INSERT;
                end
                ST_SCAN:
                begin
                    if (scan_better)
                    begin
                        vic_found_reg <= 1'b1;
                        vic_idx_reg   <= scan_idx_reg;
                        vic_cnt_reg   <= count_reg[scan_idx_reg];
                        vic_rank_reg  <= rank_reg[scan_idx_reg];
                    end
                    if (scan_idx_reg == IDX_W'(CAPACITY - 1))
                        state_reg <= ST_EVICT;
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                ST_EVICT:
                begin
                    if (vic_found_reg)
                    begin
                        valid_reg[vic_idx_reg] <= 1'b0;
                        occ_reg                <= occ_reg - 1'b1;
                        res_reg.evicted        <= 1'b1;
                        res_reg.evicted_key    <= key_reg[vic_idx_reg];
                    end
                    state_reg <= ST_INSERT;
                end
                ST_INSERT:
                begin
                    if (free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        occ_reg             <= occ_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // entry payload: keys, values, counts and recency ranks
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_DECIDE:
            begin
                if (!cur_reg.bypass && hit_reg)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i] && rank_reg[i] < rank_reg[slot_reg])
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                    rank_reg[slot_reg] <= '0;
                    if (count_reg[slot_reg] != '1)
                        count_reg[slot_reg] <= count_reg[slot_reg] + 1'b1;
                    if (is_put)
                        value_reg[slot_reg] <= cur_reg.req.store_value;
                end
            end
            ST_EVICT:
            begin
                if (vic_found_reg)
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i] && rank_reg[i] > vic_rank_reg)
                            rank_reg[i] <= rank_reg[i] - 1'b1;
            end
            ST_INSERT:
            begin
                if (free_any)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (valid_reg[i])
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                    key_reg[free_idx]   <= cur_reg.req.lookup_key;
                    value_reg[free_idx] <= cur_reg.req.store_value;
                    count_reg[free_idx] <= COUNT_BITS'(1);
                    rank_reg[free_idx]  <= '0;
                end
            end
            default: ;
        endcase
    end

    // occupancy tracks the valid bits
    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= CAPACITY)
        else $error("occupancy above table size");

    a_evict_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT && vic_found_reg) |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("eviction did not free an entry");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !rsp.ready) |=> state_reg == ST_DONE)
        else $error("result overwritten while output stalled");

endmodule
